// ===== hw/rtl/modbus_rtu_master_framer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH
`define MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define MRM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("modbus framer assertion failed");

// Checks that a value is unchanged in the cycle after a condition.
`define MRM_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
  `MRM_ASSERT(label, clk, rst_n, (cond) |=> $stable(sig))

`endif

// ===== hw/rtl/mrm_pkg.sv =====
package mrm_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [1:0] MODE_SEND     = 2'd0;
  localparam logic [1:0] MODE_RX       = 2'd1;
  localparam logic [1:0] MODE_LINE_ERR = 2'd2;

  localparam logic [7:0]  FC_WRITE   = 8'h06;
  localparam logic [7:0]  ADDR_RESET = 8'h01;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [3:0] RX_NEED_READ  = 4'd7;
  localparam logic [3:0] RX_NEED_WRITE = 4'd8;
  localparam logic [3:0] RX_CRC5_CNT   = 4'd5;
  localparam logic [3:0] RX_CRC6_CNT   = 4'd6;

  localparam logic [2:0] IDX_ADDR   = 3'd0;
  localparam logic [2:0] IDX_CODE   = 3'd1;
  localparam logic [2:0] IDX_REG_HI = 3'd2;
  localparam logic [2:0] IDX_REG_LO = 3'd3;
  localparam logic [2:0] IDX_B4     = 3'd4;
  localparam logic [2:0] IDX_B5     = 3'd5;
  localparam logic [2:0] IDX_CRC_LO = 3'd6;
  localparam logic [2:0] IDX_CRC_HI = 3'd7;

  typedef enum logic [2:0] {
    EV_TX_BYTE  = 3'd0,
    EV_READ_OK  = 3'd1,
    EV_WRITE_OK = 3'd2,
    EV_CRC_ERR  = 3'd3,
    EV_LINE_ERR = 3'd4,
    EV_BUSY     = 3'd5
  } event_e;

  typedef struct packed {
    logic        is_frame;
    event_e      ev;
    logic [15:0] regnum;
    logic [15:0] data;
    logic [7:0]  addr;
    logic [7:0]  code;
    logic [7:0]  b4;
    logic [7:0]  b5;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/mrm_front.sv =====
module mrm_front
  import mrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] target_register_i,
  input  logic [7:0]  read_count_i,
  input  logic [15:0] write_value_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_valid_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        q_full_i,
  output q_wr_t       q_wr_o
);

  logic [7:0]  slave_addr_q, slave_addr_d;
  logic [3:0]  rx_count_q, rx_count_d;
  logic [7:0]  rx_frame_q [8];
  logic        read_pend_q, read_pend_d;
  logic        write_pend_q, write_pend_d;
  logic [15:0] pend_reg_q, pend_reg_d;
  logic [15:0] crc_run_q, crc_run_d;
  logic [15:0] crc5_q, crc5_d;
  logic [15:0] crc6_q, crc6_d;

  logic        accept;
  logic [2:0]  idx;
  logic [3:0]  cnt_next;
  logic [3:0]  need;
  logic [15:0] crc_new;
  logic [7:0]  fr [8];
  logic        wr_kind;
  logic        store_rx;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign idx        = rx_count_q[2:0];
  assign cnt_next   = rx_count_q + 4'd1;
  assign need       = write_pend_q ? RX_NEED_WRITE : RX_NEED_READ;
  assign crc_new    = crc16_byte((rx_count_q == 4'd0) ? CRC_INIT : crc_run_q, rx_byte_i);
  assign wr_kind    = (function_code_i == FC_WRITE);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fr[i] = (idx == 3'(i)) ? rx_byte_i : rx_frame_q[i];
    end
  end

  always_comb begin
    slave_addr_d = cfg_valid_i ? cfg_data_i : slave_addr_q;
    rx_count_d   = rx_count_q;
    read_pend_d  = read_pend_q;
    write_pend_d = write_pend_q;
    pend_reg_d   = pend_reg_q;
    crc_run_d    = crc_run_q;
    crc5_d       = crc5_q;
    crc6_d       = crc6_q;
    store_rx     = 1'b0;
    q_wr_o       = '0;
    if (accept) begin
      unique case (mode_i)
        MODE_SEND: begin
          q_wr_o.push = 1'b1;
          if (wr_kind ? write_pend_q : read_pend_q) begin
            q_wr_o.cmd.ev = EV_BUSY;
          end else begin
            q_wr_o.cmd.is_frame = 1'b1;
            q_wr_o.cmd.ev       = EV_TX_BYTE;
            q_wr_o.cmd.regnum   = target_register_i;
            q_wr_o.cmd.addr     = slave_addr_q;
            q_wr_o.cmd.code     = function_code_i;
            q_wr_o.cmd.b4       = wr_kind ? write_value_i[15:8] : 8'h00;
            q_wr_o.cmd.b5       = wr_kind ? write_value_i[7:0] : read_count_i;
            if (wr_kind) begin
              write_pend_d = 1'b1;
            end else begin
              read_pend_d = 1'b1;
            end
            pend_reg_d = target_register_i;
          end
        end
        MODE_RX: begin
          if (read_pend_q || write_pend_q) begin
            store_rx   = 1'b1;
            rx_count_d = cnt_next;
            crc_run_d  = crc_new;
            if (cnt_next == RX_CRC5_CNT) begin
              crc5_d = crc_new;
            end
            if (cnt_next == RX_CRC6_CNT) begin
              crc6_d = crc_new;
            end
            if (cnt_next == need) begin
              q_wr_o.push       = 1'b1;
              q_wr_o.cmd.regnum = pend_reg_q;
              if (read_pend_q) begin
                if ({fr[6], fr[5]} == crc5_q) begin
                  q_wr_o.cmd.ev   = EV_READ_OK;
                  q_wr_o.cmd.data = {fr[3], fr[4]};
                end else begin
                  q_wr_o.cmd.ev = EV_CRC_ERR;
                end
                read_pend_d = 1'b0;
              end else begin
                if ({fr[7], fr[6]} == crc6_q) begin
                  q_wr_o.cmd.ev   = EV_WRITE_OK;
                  q_wr_o.cmd.data = {fr[4], fr[5]};
                end else begin
                  q_wr_o.cmd.ev = EV_CRC_ERR;
                end
                write_pend_d = 1'b0;
              end
              pend_reg_d = '0;
              rx_count_d = '0;
            end
          end
        end
        MODE_LINE_ERR: begin
          q_wr_o.push   = 1'b1;
          q_wr_o.cmd.ev = EV_LINE_ERR;
          rx_count_d    = '0;
          read_pend_d   = 1'b0;
          write_pend_d  = 1'b0;
          pend_reg_d    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= ADDR_RESET;
      rx_count_q   <= '0;
      read_pend_q  <= 1'b0;
      write_pend_q <= 1'b0;
      pend_reg_q   <= '0;
    end else begin
      slave_addr_q <= slave_addr_d;
      rx_count_q   <= rx_count_d;
      read_pend_q  <= read_pend_d;
      write_pend_q <= write_pend_d;
      pend_reg_q   <= pend_reg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_run_q <= crc_run_d;
    crc5_q    <= crc5_d;
    crc6_q    <= crc6_d;
    if (store_rx) begin
      rx_frame_q[idx] <= rx_byte_i;
    end
  end

endmodule

// ===== hw/rtl/mrm_queue.sv =====
module mrm_queue
  import mrm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t wr_i,
  output logic  full_o,
  input  logic  pop_i,
  output q_rd_t rd_o
);

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q;
  logic           push;
  logic           pop;

  assign full_o      = (count_q == (QAW + 1)'(QDEPTH));
  assign rd_o.valid  = (count_q != '0);
  assign rd_o.cmd    = mem_q[rd_ptr_q];
  assign push        = wr_i.push && !full_o;
  assign pop         = pop_i && rd_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.cmd;
    end
  end

endmodule

// ===== hw/rtl/mrm_back.sv =====
module mrm_back
  import mrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_rd_t       q_rd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [15:0] reply_register_o,
  output logic [15:0] data_word_o
);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_BUSY = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  event_e      ev_q, ev_d;
  logic [7:0]  tx_q, tx_d;
  logic        last_q, last_d;
  logic [15:0] reg_q, reg_d;
  logic [15:0] data_q, data_d;

  logic        load;
  logic        done;
  logic [7:0]  byte_sel;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    case (idx_q)
      IDX_ADDR:   byte_sel = cur_q.addr;
      IDX_CODE:   byte_sel = cur_q.code;
      IDX_REG_HI: byte_sel = cur_q.regnum[15:8];
      IDX_REG_LO: byte_sel = cur_q.regnum[7:0];
      IDX_B4:     byte_sel = cur_q.b4;
      IDX_B5:     byte_sel = cur_q.b5;
      IDX_CRC_LO: byte_sel = crc_q[7:0];
      default:    byte_sel = crc_q[15:8];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && out_stall_i;
    ev_d        = ev_q;
    tx_d        = tx_q;
    last_d      = last_q;
    reg_d       = reg_q;
    data_d      = data_q;
    q_pop_o     = 1'b0;
    done        = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_rd_i.valid) begin
          q_pop_o = 1'b1;
          cur_d   = q_rd_i.cmd;
          idx_d   = IDX_ADDR;
          state_d = BK_BUSY;
        end
      end
      BK_BUSY: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (cur_q.is_frame) begin
            ev_d   = EV_TX_BYTE;
            tx_d   = byte_sel;
            last_d = (idx_q == IDX_CRC_HI);
            reg_d  = '0;
            data_d = '0;
            if (idx_q < IDX_CRC_LO) begin
              crc_d = crc16_byte((idx_q == IDX_ADDR) ? CRC_INIT : crc_q, byte_sel);
            end
            idx_d = idx_q + 3'd1;
            done  = (idx_q == IDX_CRC_HI);
          end else begin
            ev_d   = cur_q.ev;
            tx_d   = '0;
            last_d = 1'b0;
            reg_d  = cur_q.regnum;
            data_d = cur_q.data;
            done   = 1'b1;
          end
          if (done) begin
            if (q_rd_i.valid) begin
              q_pop_o = 1'b1;
              cur_d   = q_rd_i.cmd;
              idx_d   = IDX_ADDR;
            end else begin
              state_d = BK_IDLE;
            end
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    crc_q  <= crc_d;
    ev_q   <= ev_d;
    tx_q   <= tx_d;
    last_q <= last_d;
    reg_q  <= reg_d;
    data_q <= data_d;
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = ev_q;
  assign tx_byte_o        = tx_q;
  assign last_o           = last_q;
  assign reply_register_o = reg_q;
  assign data_word_o      = data_q;

endmodule

// ===== hw/rtl/modbus_rtu_master_framer.sv =====
// Channel   Handshake                    Payload
// in        in_valid_i / in_stall_o      mode, function_code, target_register,
//                                        read_count, write_value, rx_byte
// out       out_valid_o / out_stall_i    event_res, tx_byte, last,
//                                        reply_register, data_word
// cfg       cfg_valid_i / cfg_ready_o    cfg_data_i (slave address)
//
// A send request yields eight frame bytes, one per cycle while out_stall_i is low.
// Line errors, refused sends and completed replies each yield one output event;
// an accepted command is written into the queue, popped into the back end's
// command register and then registered onto the outputs.
// A two-entry command queue separates the front and back ends, so input is
// stalled only when the queue is full. Reset is asynchronous and active low.
module modbus_rtu_master_framer
  import mrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] target_register_i,
  input  logic [7:0]  read_count_i,
  input  logic [15:0] write_value_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [15:0] reply_register_o,
  output logic [15:0] data_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  assign cfg_ready_o = 1'b1;

  mrm_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .function_code_i,
    .target_register_i,
    .read_count_i,
    .write_value_i,
    .rx_byte_i,
    .cfg_valid_i,
    .cfg_data_i,
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  mrm_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i   (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rd_o   (q_rd)
  );

  mrm_back u_back (
    .clk_i,
    .rst_ni,
    .q_rd_i  (q_rd),
    .q_pop_o (q_pop),
    .out_valid_o,
    .out_stall_i,
    .event_res_o,
    .tx_byte_o,
    .last_o,
    .reply_register_o,
    .data_word_o
  );

endmodule

// ===== hw/rtl/mrm_checker.sv =====
`include "modbus_rtu_master_framer_assert.svh"

module mrm_checker
  import mrm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  event_res_o,
  input logic [7:0]  tx_byte_o,
  input logic        last_o,
  input logic [15:0] reply_register_o,
  input logic [15:0] data_word_o
);

  logic        is_tx;
  logic [43:0] out_bundle;

  assign is_tx      = (event_res_o == EV_TX_BYTE);
  assign out_bundle = {event_res_o, tx_byte_o, last_o, reply_register_o, data_word_o};

  `MRM_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_bundle)
  `MRM_ASSERT(a_tx_no_reply, clk_i, rst_ni, out_valid_o && is_tx |-> reply_register_o == 16'h0000 && data_word_o == 16'h0000)
  `MRM_ASSERT(a_event_no_byte, clk_i, rst_ni, out_valid_o && !is_tx |-> tx_byte_o == 8'h00 && !last_o)
  `MRM_ASSERT(a_event_range, clk_i, rst_ni, out_valid_o |-> event_res_o <= EV_BUSY)

endmodule

bind modbus_rtu_master_framer mrm_checker u_mrm_checker (.*);
